// ----- rtl/core/mmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types and constants of the masked 2-D median filter.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 512;
  localparam int MAX_HALF = 7;
  localparam int WIN_SIDE = 2 * MAX_HALF + 1;
  localparam int WIN_MAX  = WIN_SIDE * WIN_SIDE;

  localparam int ROW_W   = 9;
  localparam int COL_W   = 9;
  localparam int DIM_W   = 10;
  localparam int HALF_W  = 3;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 8;
  localparam int IDX_W   = 8;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;

  localparam logic signed [DATA_W-1:0] EMPTY_FALLBACK = -32'sd655294464;

  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [IDX_W-1:0] REG_ROWS     = 8'd0;
  localparam logic [IDX_W-1:0] REG_COLS     = 8'd1;
  localparam logic [IDX_W-1:0] REG_HALF_H   = 8'd2;
  localparam logic [IDX_W-1:0] REG_HALF_W   = 8'd3;
  localparam logic [IDX_W-1:0] REG_NULL_VAL = 8'd4;
  localparam logic [IDX_W-1:0] REG_NULL_EN  = 8'd5;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic                     lt;
  } cell_link_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/mmf_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmf channel interfaces
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
interface mmf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [8:0]         row;
  logic [8:0]         col;
  logic signed [31:0] sample;
  logic               sample_invalid;
  modport source (output valid, action, row, col, sample, sample_invalid, input ready);
  modport sink   (input valid, action, row, col, sample, sample_invalid, output ready);
endinterface

interface mmf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] median;
  logic [7:0]         valid_count;
  modport source (output valid, median, valid_count, input ready);
  modport sink   (input valid, median, valid_count, output ready);
endinterface

interface mmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/masked_median_filter_2d.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_median_filter_2d
// Frame store with a masked windowed median read through a sorting cell chain.
// ----------------------------------------------------------------------------
//  channel  dir  beat content
//  in_ch    in   action, row, col, sample, sample_invalid
//  out_ch   out  median, valid_count (one beat per in-frame compute)
//  cfg      in   reg_index, data (always ready)
//
//  store: written to the frame memory at accept.
//  compute: after the accept, one memory read per window sample (up to 225),
//  then the drain and setup states and the shift phase, then the output stage.
//  rst is synchronous; the frame memory is not cleared.
//  a waiting result holds the sequencer; stores wait for it as well.
// ----------------------------------------------------------------------------
module masked_median_filter_2d
  import mmf_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  mmf_in_if.sink    in_ch,
  mmf_out_if.source out_ch,
  mmf_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DRAIN, S_SETUP, S_SHIFT, S_FINISH} state_t;

  state_t state;

  logic [DIM_W-1:0]         rows_in_use, cols_in_use;
  logic [HALF_W-1:0]        half_height, half_width;
  logic signed [DATA_W-1:0] null_value;
  logic                     null_enabled;

  logic [ROW_W-1:0] p, bot;
  logic [COL_W-1:0] q, left, right;
  logic [CNT_W-1:0] cnt, shift_cnt;
  logic             rd_pend;

  logic [DATA_W:0]  mem [DEPTH];
  logic [DATA_W:0]  rd_data;

  logic [DIM_W-1:0] nrows, ncols, row_hi, col_hi;
  logic [HALF_W-1:0] hh, hw;
  logic             in_frame, accept, keep;
  cell_ctl_t        ctl;
  cell_link_t       head0, head1;
  logic signed [DATA_W:0] pair_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= DIM_W'(MAX_ROWS);
      cols_in_use  <= DIM_W'(MAX_COLS);
      half_height  <= HALF_W'(1);
      half_width   <= HALF_W'(1);
      null_value   <= '0;
      null_enabled <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_ROWS:     rows_in_use  <= cfg.data[DIM_W-1:0];
        REG_COLS:     cols_in_use  <= cfg.data[DIM_W-1:0];
        REG_HALF_H:   half_height  <= cfg.data[HALF_W-1:0];
        REG_HALF_W:   half_width   <= cfg.data[HALF_W-1:0];
        REG_NULL_VAL: null_value   <= cfg.data;
        REG_NULL_EN:  null_enabled <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign nrows  = (rows_in_use > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_in_use;
  assign ncols  = (cols_in_use > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_in_use;
  assign hh     = (half_height > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_height;
  assign hw     = (half_width > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_width;
  assign in_frame = ({1'b0, in_ch.row} < nrows) && ({1'b0, in_ch.col} < ncols);
  assign row_hi = {1'b0, in_ch.row} + DIM_W'(hh);
  assign col_hi = {1'b0, in_ch.col} + DIM_W'(hw);

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // frame memory, single port
  always_ff @(posedge clk) begin
    if (accept && in_frame && in_ch.action == ACT_STORE) begin
      mem[{in_ch.row, in_ch.col}] <= {in_ch.sample_invalid, in_ch.sample};
    end else begin
      rd_data <= mem[{p, q}];
    end
  end

  assign keep = !rd_data[DATA_W]
             && !(null_enabled && $signed(rd_data[DATA_W-1:0]) == null_value);

  always_comb begin
    ctl.clear  = accept && in_frame && in_ch.action == ACT_COMPUTE;
    ctl.insert = rd_pend && keep && (cnt < CNT_W'(WIN_MAX));
    ctl.shift  = (state == S_SHIFT) && (shift_cnt != '0);
  end

  mmf_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sample_in ($signed(rd_data[DATA_W-1:0])),
    .head0     (head0),
    .head1     (head1)
  );

  assign pair_sum = {head0.value[DATA_W-1], head0.value}
                  + {head1.value[DATA_W-1], head1.value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_pend      <= 1'b0;
      cnt          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (ctl.insert) cnt <= cnt + CNT_W'(1);
      if (out_ch.valid && out_ch.ready && state != S_FINISH) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctl.clear) begin
            p     <= (in_ch.row > ROW_W'(hh)) ? in_ch.row - ROW_W'(hh) : '0;
            q     <= (in_ch.col > COL_W'(hw)) ? in_ch.col - COL_W'(hw) : '0;
            left  <= (in_ch.col > COL_W'(hw)) ? in_ch.col - COL_W'(hw) : '0;
            bot   <= (row_hi < nrows) ? row_hi[ROW_W-1:0] : ROW_W'(nrows - DIM_W'(1));
            right <= (col_hi < ncols) ? col_hi[COL_W-1:0] : COL_W'(ncols - DIM_W'(1));
            cnt   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (q == right) begin
            q <= left;
            if (p == bot) state <= S_DRAIN;
            else p <= p + ROW_W'(1);
          end else begin
            q <= q + COL_W'(1);
          end
        end
        S_DRAIN: state <= S_SETUP;
        S_SETUP: begin
          // odd: middle to cell 0; even: lower middle to cell 0
          shift_cnt <= (cnt[0] || cnt == '0) ? (cnt >> 1) : (cnt >> 1) - CNT_W'(1);
          state     <= S_SHIFT;
        end
        S_SHIFT: begin
          if (shift_cnt == '0) state <= S_FINISH;
          else shift_cnt <= shift_cnt - CNT_W'(1);
        end
        S_FINISH: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid       <= 1'b1;
            out_ch.valid_count <= cnt;
            if (cnt == '0) out_ch.median <= null_enabled ? null_value : EMPTY_FALLBACK;
            else if (cnt[0]) out_ch.median <= head0.value;
            else out_ch.median <= pair_sum[DATA_W:1];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WIN_MAX))
    else $error("window count beyond chain length");

  a_insert_phase: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |-> (state == S_READ || state == S_DRAIN || state == S_SETUP))
    else $error("chain insert outside the read phase");

  a_head_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && cnt != '0) |-> head0.valid)
    else $error("chain head empty with samples counted");

  a_even_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && cnt != '0 && !cnt[0]) |-> (head1.valid && head0.value <= head1.value))
    else $error("middle pair missing or out of order");

endmodule
`default_nettype wire

// ----- rtl/core/mmf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmf_cell
// One slot of the insertion sorter; keeps its chain ordered ascending.
// ----------------------------------------------------------------------------
module mmf_cell
  import mmf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctl_t                ctl,
  input  wire logic signed [DATA_W-1:0] sample_in,
  input  wire cell_link_t               prev,
  input  wire cell_link_t               next,
  output cell_link_t                    self
);

  logic                     valid;
  logic signed [DATA_W-1:0] value;
  logic                     lt;

  // empty cells act as plus infinity
  assign lt = !valid || (sample_in < value);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      if (prev.lt) begin
        valid <= prev.valid;
        value <= prev.value;
      end else if (lt) begin
        valid <= 1'b1;
        value <= sample_in;
      end
    end else if (ctl.shift) begin
      valid <= next.valid;
      value <= next.value;
    end
  end

  assign self = '{valid: valid, value: value, lt: lt};

endmodule
`default_nettype wire

// ----- rtl/core/mmf_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmf_chain
// Row of sorter cells; the two lowest cells are the read-out end.
// ----------------------------------------------------------------------------
module mmf_chain
  import mmf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctl_t                ctl,
  input  wire logic signed [DATA_W-1:0] sample_in,
  output cell_link_t                    head0,
  output cell_link_t                    head1
);

  cell_link_t links [WIN_MAX];
  cell_link_t edge_lo;
  cell_link_t edge_hi;

  assign edge_lo = '{valid: 1'b1, value: '0, lt: 1'b0};
  assign edge_hi = '{valid: 1'b0, value: '0, lt: 1'b1};

  for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
    mmf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample_in (sample_in),
      .prev      ((i == 0) ? edge_lo : links[(i == 0) ? 0 : i - 1]),
      .next      ((i == WIN_MAX - 1) ? edge_hi : links[(i == WIN_MAX - 1) ? i : i + 1]),
      .self      (links[i])
    );
  end

  assign head0 = links[0];
  assign head1 = links[(WIN_MAX > 1) ? 1 : 0];

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the masked 2-D median filter against a behavioral median predictor.
// Frames are filled through store beats before any window is read. Directed
// cases cover edges, null handling and empty windows. Random traffic then runs
// over several frame setups and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import mmf_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'd6;

  typedef struct {
    logic signed [31:0] median;
    logic [7:0]         count;
  } median_result_t;

  logic clk;
  logic rst;

  mmf_in_if  in_ch();
  mmf_out_if out_ch();
  mmf_cfg_if cfg();

  masked_median_filter_2d dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // shadow of the frame and the registers
  logic [31:0] pix_val [0:DEPTH-1];
  bit          pix_bad [0:DEPTH-1];
  bit          pix_set [0:DEPTH-1];
  logic [9:0]  rows_reg, cols_reg;
  logic [2:0]  half_h_reg, half_w_reg;
  logic signed [31:0] null_reg;
  logic        null_en_reg;

  median_result_t pending_medians[$];
  int errors, n_beats, n_results, idle_cycles;
  int send_idle_pct, sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
  endfunction

  function automatic int eff_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
  endfunction

  function automatic bit in_frame(int r, int c);
    return (r < eff_rows()) && (c < eff_cols());
  endfunction

  // clipped window bounds: top, bottom, left, right
  function automatic void window_bounds(int r, int c, output int t, output int b,
                                        output int l, output int rt);
    int hh, hw;
    hh = half_h_reg;
    hw = half_w_reg;
    t  = (r > hh) ? r - hh : 0;
    b  = (r + hh < eff_rows()) ? r + hh : eff_rows() - 1;
    l  = (c > hw) ? c - hw : 0;
    rt = (c + hw < eff_cols()) ? c + hw : eff_cols() - 1;
  endfunction

  function automatic median_result_t window_median(int r, int c);
    longint vals [0:WIN_MAX-1];
    longint key, v;
    int t, b, l, rt, k, i, j;
    median_result_t res;
    window_bounds(r, c, t, b, l, rt);
    k = 0;
    for (int p = t; p <= b; p++) begin
      for (int q = l; q <= rt; q++) begin
        if (!pix_bad[p*MAX_COLS+q]) begin
          v = longint'($signed(pix_val[p*MAX_COLS+q]));
          if (!(null_en_reg && v == longint'(null_reg))) begin
            vals[k] = v;
            k++;
          end
        end
      end
    end
    for (i = 1; i < k; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (k == 0) res.median = null_en_reg ? null_reg : EMPTY_FALLBACK;
    else if (k % 2 == 1) res.median = vals[k/2][31:0];
    else res.median = 32'((vals[k/2-1] + vals[k/2]) >>> 1);
    res.count = k[7:0];
    return res;
  endfunction

  // update the shadow for one accepted input beat
  function automatic void apply_beat(logic act, int r, int c, logic [31:0] s, logic bad);
    if (!in_frame(r, c)) return;
    if (act == ACT_STORE) begin
      pix_val[r*MAX_COLS+c] = s;
      pix_bad[r*MAX_COLS+c] = bad;
      pix_set[r*MAX_COLS+c] = 1'b1;
    end else begin
      pending_medians.push_back(window_median(r, c));
    end
  endfunction

  task automatic send_beat(logic act, int r, int c, logic [31:0] s, logic bad);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.row            <= r[8:0];
    in_ch.col            <= c[8:0];
    in_ch.sample         <= s;
    in_ch.sample_invalid <= bad;
    do @(posedge clk); while (!in_ch.ready);
    n_beats++;
    apply_beat(act, r, c, s, bad);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return null_reg;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom_range(0, 5) << 16;
      default: return $urandom;
    endcase
  endfunction

  // store every not yet written sample that the window would read
  task automatic fill_window(int r, int c);
    int t, b, l, rt;
    if (!in_frame(r, c)) return;
    window_bounds(r, c, t, b, l, rt);
    for (int p = t; p <= b; p++)
      for (int q = l; q <= rt; q++)
        if (!pix_set[p*MAX_COLS+q])
          send_beat(ACT_STORE, p, q, pick_sample(), $urandom_range(0, 9) == 0);
  endtask

  task automatic compute_at(int r, int c);
    fill_window(r, c);
    send_beat(ACT_COMPUTE, r, c, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_medians.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_ROWS:     rows_reg    = data[9:0];
      REG_COLS:     cols_reg    = data[9:0];
      REG_HALF_H:   half_h_reg  = data[2:0];
      REG_HALF_W:   half_w_reg  = data[2:0];
      REG_NULL_VAL: null_reg    = data;
      REG_NULL_EN:  null_en_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(int r, int c, int hh, int hw, logic [31:0] nv, logic en);
    wait_drained();
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    write_reg(REG_HALF_H, hh);
    write_reg(REG_HALF_W, hw);
    write_reg(REG_NULL_VAL, nv);
    write_reg(REG_NULL_EN, 32'(en));
    cfg.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    median_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_medians.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: median %0d count %0d",
                                   out_ch.median, out_ch.valid_count);
      end else begin
        e = pending_medians.pop_front();
        if (out_ch.median !== e.median || out_ch.valid_count !== e.count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected median %0d count %0d, got median %0d count %0d",
                     e.median, e.count, out_ch.median, out_ch.valid_count);
        end
      end
    end
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

  // watchdog on beats of any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    configure(4, 4, 1, 1, 32'h0001_0000, 1'b1);
    send_beat(ACT_STORE, 0, 0, 32'h7FFF_FFFF, 1'b0);
    send_beat(ACT_STORE, 0, 1, 32'h8000_0000, 1'b0);
    send_beat(ACT_STORE, 0, 2, 32'h0002_0000, 1'b1);
    send_beat(ACT_STORE, 0, 3, 32'h0001_0000, 1'b0);
    send_beat(ACT_STORE, 5, 0, 32'h1234_5678, 1'b0);   // outside the frame
    compute_at(0, 0);
    compute_at(3, 3);
    compute_at(1, 2);
    send_beat(ACT_COMPUTE, 4, 4, 0, 1'b0);             // outside the frame
    // even count: extremes average to minus one
    configure(4, 4, 0, 1, 32'h0001_0000, 1'b1);
    compute_at(0, 0);
    // single-sample windows: invalid, null, and then null disabled
    configure(4, 4, 0, 0, 32'h0001_0000, 1'b1);
    compute_at(0, 2);
    compute_at(0, 3);
    configure(4, 4, 0, 0, 32'h0001_0000, 1'b0);
    compute_at(0, 2);
    compute_at(0, 3);
    // masked data bits and an unknown index
    wait_drained();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_ROWS, 32'hFFFF_FC04);
    cfg.valid <= 1'b0;
    compute_at(3, 0);
    // largest frame and window, far corners
    configure(512, 512, 7, 7, 32'h8000_0000, 1'b1);
    compute_at(511, 511);
    compute_at(0, 511);
  endtask

  task automatic test_random(int phase, int slot);
    int r, c;
    case (slot)
      0: configure(512, 512, 7, 7, pick_sample(), 1'($urandom_range(0, 1)));
      1: configure(1, 512, $urandom_range(0, 7), $urandom_range(0, 7), pick_sample(), 1'b1);
      2: configure(512, 1, $urandom_range(0, 7), $urandom_range(0, 7), 0,
                   1'($urandom_range(0, 1)));
      3: if (phase == 0) configure(0, 8, 1, 1, 0, 1'b1);
         else if (phase == 1) configure(1023, 700, 2, 3, 32'hFFFF_0000, 1'b1);
         else configure($urandom_range(1, 16), $urandom_range(1, 16), 7, 0, 0, 1'b1);
      default: configure($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 3) << 16,
                         1'($urandom_range(0, 1)));
    endcase
    for (int n = 0; n < 20; n++) begin
      // every frame setup works in the top-left patch so that fills remain short
      r = $urandom_range(0, 15);
      c = $urandom_range(0, 15);
      if (eff_rows() > 0 && r >= eff_rows()) r = eff_rows() - 1;
      if (eff_cols() > 0 && c >= eff_cols()) c = eff_cols() - 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: compute_at(r, c);
        6, 7, 8: send_beat(ACT_STORE, r, c, pick_sample(), $urandom_range(0, 7) == 0);
        default: begin
          r = $urandom_range(0, 511);
          c = $urandom_range(0, 511);
          if (in_frame(r, c)) send_beat(ACT_STORE, r, c, $urandom, 1'($urandom_range(0, 1)));
          else send_beat(1'($urandom_range(0, 1)), r, c, $urandom, 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin
    int idle_set [4] = '{0, 50, 0, 11};
    int stall_set [4] = '{0, 0, 50, 11};
    in_ch.valid = 1'b0;
    in_ch.action = ACT_STORE;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.sample = '0;
    in_ch.sample_invalid = 1'b0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_ROWS;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    errors = 0;
    n_beats = 0;
    n_results = 0;
    idle_cycles = 0;
    rows_reg = 10'd512;
    cols_reg = 10'd512;
    half_h_reg = 3'd1;
    half_w_reg = 3'd1;
    null_reg = '0;
    null_en_reg = 1'b1;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      sink_stall_pct = stall_set[ph];
      for (int s = 0; s < 7; s++) test_random(ph, s);
    end
    wait_drained();
    $display("covered %0d input beats and %0d median results over edge, null,",
             n_beats, n_results);
    $display("empty-window, clipped and idle-pattern cases");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
